// File: rtl/core/fbc_pkg.sv
// shared types, s-box table and subkey schedule for the 64-bit feistel cipher
package fbc_pkg;

  localparam int unsigned ROUNDS = 16;
  localparam int unsigned KEY_W = 64;

  // register indexes on the configuration port
  localparam logic REG_KEY  = 1'b0;
  localparam logic REG_MODE = 1'b1;

  // four 16-bit words of the block, r0 most significant
  typedef struct packed {
    logic [15:0] r0;
    logic [15:0] r1;
    logic [15:0] r2;
    logic [15:0] r3;
  } blk_t;

  // subkey bytes of one round: group (g0, g1, f words) by byte
  typedef logic [2:0][3:0][7:0] rkey_t;

  localparam logic [7:0] SBOX [256] = '{
    8'ha3,8'hd7,8'h09,8'h83,8'hf8,8'h48,8'hf6,8'hf4,8'hb3,8'h21,8'h15,8'h78,8'h99,8'hb1,8'haf,8'hf9,
    8'he7,8'h2d,8'h4d,8'h8a,8'hce,8'h4c,8'hca,8'h2e,8'h52,8'h95,8'hd9,8'h1e,8'h4e,8'h38,8'h44,8'h28,
    8'h0a,8'hdf,8'h02,8'ha0,8'h17,8'hf1,8'h60,8'h68,8'h12,8'hb7,8'h7a,8'hc3,8'he9,8'hfa,8'h3d,8'h53,
    8'h96,8'h84,8'h6b,8'hba,8'hf2,8'h63,8'h9a,8'h19,8'h7c,8'hae,8'he5,8'hf5,8'hf7,8'h16,8'h6a,8'ha2,
    8'h39,8'hb6,8'h7b,8'h0f,8'hc1,8'h93,8'h81,8'h1b,8'hee,8'hb4,8'h1a,8'hea,8'hd0,8'h91,8'h2f,8'hb8,
    8'h55,8'hb9,8'hda,8'h85,8'h3f,8'h41,8'hbf,8'he0,8'h5a,8'h58,8'h80,8'h5f,8'h66,8'h0b,8'hd8,8'h90,
    8'h35,8'hd5,8'hc0,8'ha7,8'h33,8'h06,8'h65,8'h69,8'h45,8'h00,8'h94,8'h56,8'h6d,8'h98,8'h9b,8'h76,
    8'h97,8'hfc,8'hb2,8'hc2,8'hb0,8'hfe,8'hdb,8'h20,8'he1,8'heb,8'hd6,8'he4,8'hdd,8'h47,8'h4a,8'h1d,
    8'h42,8'hed,8'h9e,8'h6e,8'h49,8'h3c,8'hcd,8'h43,8'h27,8'hd2,8'h07,8'hd4,8'hde,8'hc7,8'h67,8'h18,
    8'h89,8'hcb,8'h30,8'h1f,8'h8d,8'hc6,8'h8f,8'haa,8'hc8,8'h74,8'hdc,8'hc9,8'h5d,8'h5c,8'h31,8'ha4,
    8'h70,8'h88,8'h61,8'h2c,8'h9f,8'h0d,8'h2b,8'h87,8'h50,8'h82,8'h54,8'h64,8'h26,8'h7d,8'h03,8'h40,
    8'h34,8'h4b,8'h1c,8'h73,8'hd1,8'hc4,8'hfd,8'h3b,8'hcc,8'hfb,8'h7f,8'hab,8'he6,8'h3e,8'h5b,8'ha5,
    8'had,8'h04,8'h23,8'h9c,8'h14,8'h51,8'h22,8'hf0,8'h29,8'h79,8'h71,8'h7e,8'hff,8'h8c,8'h0e,8'he2,
    8'h0c,8'hef,8'hbc,8'h72,8'h75,8'h6f,8'h37,8'ha1,8'hec,8'hd3,8'h8e,8'h62,8'h8b,8'h86,8'h10,8'he8,
    8'h08,8'h77,8'h11,8'hbe,8'h92,8'h4f,8'h24,8'hc5,8'h32,8'h36,8'h9d,8'hcf,8'hf3,8'ha6,8'hbb,8'hac,
    8'h5e,8'h6c,8'ha9,8'h13,8'h57,8'h25,8'hb5,8'he3,8'hbd,8'ha8,8'h3a,8'h01,8'h05,8'h59,8'h2a,8'h46
  };

  // subkey bytes of one round; the round number is constant at each stage,
  // so this reduces to fixed wiring from the key register
  function automatic rkey_t round_keys(logic [KEY_W-1:0] key, int unsigned rnd);
    rkey_t       rk;
    logic [KEY_W-1:0] rot;
    int unsigned s;
    int unsigned n;
    int unsigned bsel;
    rk = '0;
    for (int unsigned g = 0; g < 3; g++) begin
      for (int unsigned j = 0; j < 4; j++) begin
        s    = 12 * rnd + 4 * g + j;
        n    = (s + 1) % KEY_W;
        rot  = (key << n) | (key >> (KEY_W - n));
        bsel = (4 * rnd + j) % 8;
        rk[g][j] = rot[8*bsel +: 8];
      end
    end
    return rk;
  endfunction

endpackage

// File: rtl/core/fbc_in_if.sv
// input block channel: valid, ready and the block to transform
interface fbc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_in;

  modport source (output valid, output data_in, input ready);
  modport sink   (input valid, input data_in, output ready);
endinterface

// File: rtl/core/fbc_out_if.sv
// output block channel: valid, ready and the transformed block
interface fbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

// File: rtl/core/fbc_round.sv
// one feistel round split over two register stages
module fbc_round import fbc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  dec,
  input  rkey_t rk,
  input  logic  in_valid,
  input  blk_t  in_blk,
  output logic  out_valid,
  output blk_t  out_blk
);

  // first half of g: two s-box steps for each of the words r0 and r1
  logic [7:0] c0, d0, c1, d1;
  logic       a_valid;
  blk_t       a_blk;
  logic [7:0] a_c0, a_d0, a_c1, a_d1;

  always_comb begin
    c0 = SBOX[in_blk.r0[7:0] ^ rk[0][0]] ^ in_blk.r0[15:8];
    d0 = SBOX[c0 ^ rk[0][1]] ^ in_blk.r0[7:0];
    c1 = SBOX[in_blk.r1[7:0] ^ rk[1][0]] ^ in_blk.r1[15:8];
    d1 = SBOX[c1 ^ rk[1][1]] ^ in_blk.r1[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_blk <= in_blk;
      a_c0  <= c0;
      a_d0  <= d0;
      a_c1  <= c1;
      a_d1  <= d1;
    end
  end

  // second half of g, then f and the word update
  logic [7:0]  e0, f0, e1, f1;
  logic [15:0] t0, t1, fa, fb, ka, kb, x, n0, n1;

  always_comb begin
    e0 = SBOX[a_d0 ^ rk[0][2]] ^ a_c0;
    f0 = SBOX[e0 ^ rk[0][3]] ^ a_d0;
    e1 = SBOX[a_d1 ^ rk[1][2]] ^ a_c1;
    f1 = SBOX[e1 ^ rk[1][3]] ^ a_d1;
    t0 = {e0, f0};
    t1 = {e1, f1};
    ka = {rk[2][0], rk[2][1]};
    kb = {rk[2][2], rk[2][3]};
    fa = t0 + {t1[14:0], 1'b0} + ka;
    fb = {t0[14:0], 1'b0} + t1 + kb;
    if (dec) begin
      x  = a_blk.r3 ^ fb;
      n0 = {a_blk.r2[14:0], a_blk.r2[15]} ^ fa;
      n1 = {x[0], x[15:1]};
    end else begin
      x  = a_blk.r2 ^ fa;
      n0 = {x[0], x[15:1]};
      n1 = {a_blk.r3[14:0], a_blk.r3[15]} ^ fb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_blk <= '{r0: n0, r1: n1, r2: a_blk.r0, r3: a_blk.r1};
    end
  end

endmodule

// File: rtl/core/feistel_block_cipher_64.sv
// 64-bit feistel block cipher engine, fully unrolled, with apb configuration
// Takes one 64-bit block per cycle while the output is not stalled and shows
// each transformed block on the output once it has passed one whitening stage
// plus two register stages for each of the 16 rounds (two s-box steps of g per
// stage), with the output whitening done on the way out. The whole
// pipeline advances together, so a stall on the output holds every stage;
// blocks leave in the order they came. The key and mode registers feed the
// rounds directly and are to be written only while no block is in flight.
// Register 0 (byte address 0) is the 64-bit key, register 1 (byte address 8)
// selects decryption in bit 0.
module feistel_block_cipher_64 import fbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  fbc_in_if.sink      blk_in,
  fbc_out_if.source   blk_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [KEY_W-1:0] cipher_key;
  logic             decrypt_mode;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key   <= '0;
      decrypt_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[3])
        REG_KEY:  cipher_key   <= pwdata;
        REG_MODE: decrypt_mode <= pwdata[0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_KEY:  prdata = cipher_key;
      REG_MODE: prdata = {63'd0, decrypt_mode};
      default:  prdata = '0;
    endcase
  end

  // pipeline advance: move whenever the output stage is empty or drained
  logic en;
  logic in_vld;
  blk_t in_st;
  logic vld [ROUNDS+1];
  blk_t st  [ROUNDS+1];

  assign en           = !vld[ROUNDS] || blk_out.ready;
  assign blk_in.ready = en;

  // input whitening stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (en) begin
      in_vld <= blk_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_st <= blk_in.data_in ^ cipher_key;
    end
  end

  assign vld[0] = in_vld;
  assign st[0]  = in_st;

  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    rkey_t rk;

    // decryption runs the rounds' subkeys in reverse order
    assign rk = decrypt_mode ? round_keys(cipher_key, ROUNDS - 1 - i)
                             : round_keys(cipher_key, i);

    fbc_round u_round (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .dec       (decrypt_mode),
      .rk        (rk),
      .in_valid  (vld[i]),
      .in_blk    (st[i]),
      .out_valid (vld[i+1]),
      .out_blk   (st[i+1])
    );
  end

  // words reordered and whitened again on the way out
  assign blk_out.valid    = vld[ROUNDS];
  assign blk_out.data_out = {st[ROUNDS].r2, st[ROUNDS].r3, st[ROUNDS].r0, st[ROUNDS].r1}
                            ^ cipher_key;

endmodule

// File: rtl/core/fbc_checker.sv
// port-level checks on the cipher engine, bound to the top level
module fbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] data_out
);

  // a result that is not taken stays on the port unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_out))
    else $error("stalled result changed or vanished");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // with the output stage free the pipeline always takes a block
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with output stage empty");

  // a drained output frees the input in the same cycle
  a_ready_pass: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output is being taken");

endmodule

bind feistel_block_cipher_64 fbc_checker u_fbc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (blk_in.ready),
  .out_valid (blk_out.valid),
  .out_ready (blk_out.ready),
  .data_out  (blk_out.data_out)
);

// File: sim/feistel_block_cipher_64_check.sv
// checker for the feistel cipher: snoops config writes, predicts each block and compares
module feistel_block_cipher_64_check import fbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic [63:0] prdata,
  input  logic        pready,
  output int unsigned failures,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] KEY_ADDR  = {REG_KEY, 3'b000};
  localparam logic [3:0] MODE_ADDR = {REG_MODE, 3'b000};
  localparam int unsigned NUM_ROUNDS = 16;

  localparam logic [7:0] SUBST_BOX [256] = '{
    8'ha3,8'hd7,8'h09,8'h83,8'hf8,8'h48,8'hf6,8'hf4,8'hb3,8'h21,8'h15,8'h78,8'h99,8'hb1,8'haf,8'hf9,
    8'he7,8'h2d,8'h4d,8'h8a,8'hce,8'h4c,8'hca,8'h2e,8'h52,8'h95,8'hd9,8'h1e,8'h4e,8'h38,8'h44,8'h28,
    8'h0a,8'hdf,8'h02,8'ha0,8'h17,8'hf1,8'h60,8'h68,8'h12,8'hb7,8'h7a,8'hc3,8'he9,8'hfa,8'h3d,8'h53,
    8'h96,8'h84,8'h6b,8'hba,8'hf2,8'h63,8'h9a,8'h19,8'h7c,8'hae,8'he5,8'hf5,8'hf7,8'h16,8'h6a,8'ha2,
    8'h39,8'hb6,8'h7b,8'h0f,8'hc1,8'h93,8'h81,8'h1b,8'hee,8'hb4,8'h1a,8'hea,8'hd0,8'h91,8'h2f,8'hb8,
    8'h55,8'hb9,8'hda,8'h85,8'h3f,8'h41,8'hbf,8'he0,8'h5a,8'h58,8'h80,8'h5f,8'h66,8'h0b,8'hd8,8'h90,
    8'h35,8'hd5,8'hc0,8'ha7,8'h33,8'h06,8'h65,8'h69,8'h45,8'h00,8'h94,8'h56,8'h6d,8'h98,8'h9b,8'h76,
    8'h97,8'hfc,8'hb2,8'hc2,8'hb0,8'hfe,8'hdb,8'h20,8'he1,8'heb,8'hd6,8'he4,8'hdd,8'h47,8'h4a,8'h1d,
    8'h42,8'hed,8'h9e,8'h6e,8'h49,8'h3c,8'hcd,8'h43,8'h27,8'hd2,8'h07,8'hd4,8'hde,8'hc7,8'h67,8'h18,
    8'h89,8'hcb,8'h30,8'h1f,8'h8d,8'hc6,8'h8f,8'haa,8'hc8,8'h74,8'hdc,8'hc9,8'h5d,8'h5c,8'h31,8'ha4,
    8'h70,8'h88,8'h61,8'h2c,8'h9f,8'h0d,8'h2b,8'h87,8'h50,8'h82,8'h54,8'h64,8'h26,8'h7d,8'h03,8'h40,
    8'h34,8'h4b,8'h1c,8'h73,8'hd1,8'hc4,8'hfd,8'h3b,8'hcc,8'hfb,8'h7f,8'hab,8'he6,8'h3e,8'h5b,8'ha5,
    8'had,8'h04,8'h23,8'h9c,8'h14,8'h51,8'h22,8'hf0,8'h29,8'h79,8'h71,8'h7e,8'hff,8'h8c,8'h0e,8'he2,
    8'h0c,8'hef,8'hbc,8'h72,8'h75,8'h6f,8'h37,8'ha1,8'hec,8'hd3,8'h8e,8'h62,8'h8b,8'h86,8'h10,8'he8,
    8'h08,8'h77,8'h11,8'hbe,8'h92,8'h4f,8'h24,8'hc5,8'h32,8'h36,8'h9d,8'hcf,8'hf3,8'ha6,8'hbb,8'hac,
    8'h5e,8'h6c,8'ha9,8'h13,8'h57,8'h25,8'hb5,8'he3,8'hbd,8'ha8,8'h3a,8'h01,8'h05,8'h59,8'h2a,8'h46
  };

  logic [63:0] key_shadow;
  logic        decrypt_shadow;
  logic [63:0] blocks_due [$];
  logic [63:0] due_block;
  logic [63:0] reg_value;

  // byte of the key schedule: key spun left by s+1 bits, byte picked from the round and step
  function automatic logic [7:0] sched_byte(logic [63:0] key, int unsigned rnd,
                                            int unsigned g, int unsigned j);
    logic [127:0] spun;
    int unsigned  s;
    int unsigned  pick;
    s    = 12 * rnd + 4 * g + j;
    spun = {key, key} << ((s + 1) % 64);
    pick = (4 * rnd + j) % 8;
    return spun[64 + 8 * pick +: 8];
  endfunction

  function automatic logic [15:0] g_word(logic [63:0] key, logic [15:0] w,
                                         int unsigned rnd, int unsigned g);
    logic [7:0] t [6];
    t[0] = w[15:8];
    t[1] = w[7:0];
    for (int unsigned k = 0; k < 4; k++)
      t[k + 2] = SUBST_BOX[t[k + 1] ^ sched_byte(key, rnd, g, k)] ^ t[k];
    return {t[4], t[5]};
  endfunction

  function automatic logic [63:0] cipher_block(logic [63:0] key, logic dec, logic [63:0] blk);
    logic [15:0] w [4];
    logic [15:0] kw [4];
    logic [15:0] t0, t1, fk_a, fk_b, f0, f1, x, n0, n1;
    int unsigned rnd;
    for (int unsigned i = 0; i < 4; i++) begin
      kw[i] = key[63 - 16 * i -: 16];
      w[i]  = blk[63 - 16 * i -: 16] ^ kw[i];
    end
    for (int unsigned i = 0; i < NUM_ROUNDS; i++) begin
      rnd  = dec ? (NUM_ROUNDS - 1 - i) : i;
      t0   = g_word(key, w[0], rnd, 0);
      t1   = g_word(key, w[1], rnd, 1);
      fk_a = {sched_byte(key, rnd, 2, 0), sched_byte(key, rnd, 2, 1)};
      fk_b = {sched_byte(key, rnd, 2, 2), sched_byte(key, rnd, 2, 3)};
      f0   = t0 + {t1[14:0], 1'b0} + fk_a;
      f1   = {t0[14:0], 1'b0} + t1 + fk_b;
      if (dec) begin
        n0 = {w[2][14:0], w[2][15]} ^ f0;
        x  = w[3] ^ f1;
        n1 = {x[0], x[15:1]};
      end else begin
        x  = w[2] ^ f0;
        n0 = {x[0], x[15:1]};
        n1 = {w[3][14:0], w[3][15]} ^ f1;
      end
      w[2] = w[0];
      w[3] = w[1];
      w[0] = n0;
      w[1] = n1;
    end
    return {w[2] ^ kw[0], w[3] ^ kw[1], w[0] ^ kw[2], w[1] ^ kw[3]};
  endfunction

  task automatic report_mismatch(input string what);
    failures++;
    $display("%0t: mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      key_shadow     = '0;
      decrypt_shadow = 1'b0;
      blocks_due.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == KEY_ADDR)
            key_shadow = pwdata;
          else if (paddr == MODE_ADDR)
            decrypt_shadow = pwdata[0];
        end else if (paddr == KEY_ADDR || paddr == MODE_ADDR) begin
          reg_value = (paddr == KEY_ADDR) ? key_shadow : {63'b0, decrypt_shadow};
          if (prdata !== reg_value)
            report_mismatch($sformatf("register at %0d reads %h, expected %h",
                                      paddr, prdata, reg_value));
        end
      end
      if (in_valid && in_ready)
        blocks_due.push_back(cipher_block(key_shadow, decrypt_shadow, in_data));
      if (out_valid && out_ready) begin
        if (blocks_due.size() == 0) begin
          report_mismatch($sformatf("block %h came out with none expected", out_data));
        end else begin
          due_block = blocks_due.pop_front();
          if (out_data !== due_block)
            report_mismatch($sformatf("data_out %h, expected %h", out_data, due_block));
        end
      end
    end
    pending <= blocks_due.size();
  end

endmodule

// File: sim/feistel_block_cipher_64_tb.sv
// testbench top for the feistel cipher: clock, reset, stimulus, receiver stalls and verdict
module feistel_block_cipher_64_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fbc_pkg::*;

  localparam logic [3:0]  KEY_ADDR     = {REG_KEY, 3'b000};
  localparam logic [3:0]  MODE_ADDR    = {REG_MODE, 3'b000};
  localparam logic [63:0] MODE_ENCRYPT = 64'd0;
  localparam logic [63:0] MODE_DECRYPT = 64'd1;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 240;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  int unsigned failures;
  int unsigned pending;
  int unsigned cycle_count;
  int unsigned burst_left;
  bit          hold_req;
  bit          hold_done;

  fbc_in_if  blk_in ();
  fbc_out_if blk_out ();

  feistel_block_cipher_64 i_dut (
    .clk     (clk),
    .rst     (rst),
    .blk_in  (blk_in),
    .blk_out (blk_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  feistel_block_cipher_64_check i_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (blk_in.valid),
    .in_ready  (blk_in.ready),
    .in_data   (blk_in.data_in),
    .out_valid (blk_out.valid),
    .out_ready (blk_out.ready),
    .out_data  (blk_out.data_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [63:0] pick_block();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      3:       return ~(64'd1 << $urandom_range(0, 63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // a setup phase then an access phase; called and returns at a falling edge
  task automatic apb_access(input logic wr, input logic [3:0] addr, input logic [63:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_regs(input logic [63:0] key, input logic [63:0] mode);
    apb_access(1'b1, KEY_ADDR, key);
    apb_access(1'b1, MODE_ADDR, mode);
    apb_access(1'b0, KEY_ADDR, '0);
    apb_access(1'b0, MODE_ADDR, '0);
  endtask

  // bursts of random length; valid stays high across items inside a burst
  task automatic send_block(input logic [63:0] blk);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        blk_in.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    blk_in.valid   = 1'b1;
    blk_in.data_in = blk;
    @(posedge clk);
    while (!blk_in.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain();
    blk_in.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // receiver: ready pattern of its own, plus one long hold-off to fill the pipeline
  initial begin
    int unsigned kind;
    int unsigned span;
    blk_out.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done     = 1'b1;
        blk_out.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      kind = $urandom_range(0, 9);
      span = $urandom_range(10, 120);
      for (int unsigned c = 0; c < span && !(hold_req && !hold_done); c++) begin
        @(negedge clk);
        case (kind)
          0, 1, 2, 3: blk_out.ready = 1'b1;
          4, 5, 6, 7: blk_out.ready = ($urandom_range(0, 3) != 0);
          8:          blk_out.ready = ($urandom_range(0, 3) == 0);
          default:    blk_out.ready = (c >= 30);
        endcase
      end
    end
  end

  initial begin
    logic [63:0] phase_key;
    logic [63:0] phase_mode;
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    blk_in.valid   = 1'b0;
    blk_in.data_in = '0;
    burst_left     = 0;
    hold_req       = 1'b0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // reset values: zero key, encryption
    apb_access(1'b0, KEY_ADDR, '0);
    apb_access(1'b0, MODE_ADDR, '0);
    send_block('0);
    send_block('1);
    send_block(64'h0123_4567_89ab_cdef);
    send_block(64'h8000_0000_0000_0000);
    send_block(64'h0000_0000_0000_0001);
    drain();

    // wide mode write with low bit clear still means encryption
    set_regs('1, 64'hffff_ffff_ffff_fffe);
    send_block('0);
    send_block('1);
    send_block(64'hfedc_ba98_7654_3210);
    drain();

    // wide mode write with every bit set selects decryption
    set_regs(64'h8000_0000_0000_0001, '1);
    send_block('0);
    send_block('1);
    send_block(64'h0123_4567_89ab_cdef);
    send_block(64'h5555_5555_5555_5555);
    send_block(64'haaaa_aaaa_aaaa_aaaa);
    drain();

    set_regs('0, MODE_DECRYPT);
    send_block('0);
    send_block('1);
    drain();

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       phase_key = '1;
        1:       phase_key = '0;
        default: phase_key = {$urandom, $urandom};
      endcase
      // mode alternates per phase; the upper bits of the write are noise
      phase_mode = {$urandom, $urandom};
      phase_mode[0] = ph[0] ? MODE_DECRYPT[0] : MODE_ENCRYPT[0];
      set_regs(phase_key, phase_mode);
      if (ph == 2)
        hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_block(pick_block());
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
